@@ sv/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication that must hold at every clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Implication whose consequent is checked in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

@@ sv/pba_pkg.sv @@
// Package with the shared constants and types of the page bitmap allocator.
package pba_pkg;
   localparam int NumPages  = 65536;
   localparam int NumWords  = (NumPages + 63) / 64;
   localparam int WordAw    = $clog2(NumWords);
   localparam int PageW     = $clog2(NumPages);
   localparam int CntW      = 17;
   localparam int AddrW     = 28;

   localparam logic [2:0] FUNC_ALLOC_PAGE = 3'd0;
   localparam logic [2:0] FUNC_ALLOC_RUN  = 3'd1;
   localparam logic [2:0] FUNC_FREE_PAGE  = 3'd2;
   localparam logic [2:0] FUNC_MARK_USED  = 3'd3;
   localparam logic [2:0] FUNC_MARK_FREE  = 3'd4;

   localparam logic [1:0] STATUS_DONE    = 2'd0;
   localparam logic [1:0] STATUS_NOSPACE = 2'd1;
   localparam logic [1:0] STATUS_IGNORED = 2'd2;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_RD, ST_WAIT, ST_EXEC, ST_WR, ST_RESP
   } state_type;

   typedef struct packed {
      logic                we;
      logic [WordAw-1:0]   waddr;
      logic [63:0]         wdata;
      logic [WordAw-1:0]   raddr;
   } mem_req_type;
endpackage

@@ sv/pba_bitmap_ram.sv @@
// Bitmap word memory with one write port and one registered read port.
module pba_bitmap_ram (
   input  logic                clock,
   input  pba_pkg::mem_req_type req,
   output logic [63:0]         rdata
);
   logic [63:0] mem [pba_pkg::NumWords];

   always_ff @(posedge clock) begin
      if (req.we) begin
         mem[req.waddr] <= req.wdata;
      end
      rdata <= mem[req.raddr];
   end
endmodule

@@ sv/page_bitmap_allocator_unit.sv @@
// Top level of the page bitmap allocator: sequencer, counters and bit unit.
//
//   channel   direction  ports
//   req       in         req_valid req_stall req_func req_address req_page_count
//   rsp       out        rsp_valid rsp_stall rsp_result_address rsp_status rsp_free_count
//   csr       in         csr_we csr_wdata
//
// After reset a clearing pass writes every bitmap word as all used.
// A word is scanned by a read, a wait and a test; a changed word adds a write-back.
// Single-page allocation scans up to 1024 words; run and mark commands test the
// pages one at a time, reading each word that they touch.
// One command is in flight at a time; req_stall is high until the result is taken.
module page_bitmap_allocator_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_func,
   input  logic [27:0] req_address,
   input  logic [16:0] req_page_count,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [27:0] rsp_result_address,
   output logic [1:0]  rsp_status,
   output logic [16:0] rsp_free_count,
   input  logic        csr_we,
   input  logic [16:0] csr_wdata
);
   localparam int W  = pba_pkg::WordAw;
   localparam int PW = pba_pkg::PageW;

   pba_pkg::state_type state_ff, state_in;
   pba_pkg::mem_req_type mreq;
   logic [63:0] rdata;

   logic [16:0] total_ff;
   logic [16:0] free_ff, free_in;
   logic [16:0] hint_ff, hint_in;
   logic [2:0]  func_ff, func_in;
   logic [16:0] cnt_ff, cnt_in;      // remaining count or run target
   logic [16:0] pos_ff, pos_in;      // current page (17 bits)
   logic [16:0] start_ff, start_in;  // run start
   logic [16:0] len_ff, len_in;
   logic [W:0]  widx_ff, widx_in;    // words visited / word index
   logic        pass_ff, pass_in;
   logic        mode_ff, mode_in;    // run: 0 search, 1 fill
   logic [63:0] word_ff, word_in;
   logic        dirty_ff, dirty_in;
   logic [27:0] res_ff, res_in;
   logic [1:0]  stat_ff, stat_in;
   logic [W:0]  clr_ff, clr_in;

   logic [16:0] etotal;
   logic [W:0]  end_w, start_w, hint_w;
   logic [5:0]  lz;
   logic        word_full;
   logic [W:0]  cur_w;
   logic        bit_used;
   logic [16:0] pos_prev;

   pba_bitmap_ram u_ram (.clock(clock), .req(mreq), .rdata(rdata));

   assign etotal  = (total_ff > 17'(pba_pkg::NumPages)) ? 17'(pba_pkg::NumPages) : total_ff;
   assign end_w   = (W+1)'((etotal + 17'd63) >> 6);
   assign hint_w  = (W+1)'(hint_ff >> 6);
   assign start_w = (hint_w > end_w) ? end_w : hint_w;
   assign word_full = &word_ff;
   assign bit_used  = word_ff[pos_ff[5:0]];
   assign pos_prev  = pos_ff - 17'd1;

   always_comb begin
      lz = 6'd63;
      for (int b = 62; b >= 0; b--) begin
         if (!word_ff[b]) lz = 6'(b);
      end
   end

   // Word currently addressed: the scan index for page allocation, else the page's word.
   assign cur_w = (func_ff == pba_pkg::FUNC_ALLOC_PAGE) ? widx_ff : (W+1)'(pos_ff >> 6);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pba_pkg::ST_CLEAR;
         total_ff <= '0;
         free_ff  <= '0;
         hint_ff  <= '0;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_we) total_ff <= csr_wdata;
         free_ff  <= free_in;
         hint_ff  <= hint_in;
         clr_ff   <= clr_in;
      end
      func_ff  <= func_in;
      cnt_ff   <= cnt_in;
      pos_ff   <= pos_in;
      start_ff <= start_in;
      len_ff   <= len_in;
      widx_ff  <= widx_in;
      pass_ff  <= pass_in;
      mode_ff  <= mode_in;
      word_ff  <= word_in;
      dirty_ff <= dirty_in;
      res_ff   <= res_in;
      stat_ff  <= stat_in;
   end

   always_comb begin
      state_in = state_ff;
      free_in = free_ff; hint_in = hint_ff; func_in = func_ff; cnt_in = cnt_ff;
      pos_in = pos_ff; start_in = start_ff; len_in = len_ff; widx_in = widx_ff;
      pass_in = pass_ff; mode_in = mode_ff; word_in = word_ff; dirty_in = dirty_ff;
      res_in = res_ff; stat_in = stat_ff; clr_in = clr_ff;
      mreq.we = 1'b0; mreq.waddr = cur_w[W-1:0]; mreq.wdata = word_ff;
      mreq.raddr = cur_w[W-1:0];
      unique case (state_ff)
         pba_pkg::ST_CLEAR: begin
            mreq.we = 1'b1; mreq.waddr = clr_ff[W-1:0]; mreq.wdata = '1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (W+1)'(pba_pkg::NumWords - 1)) state_in = pba_pkg::ST_IDLE;
         end
         pba_pkg::ST_IDLE: begin
            if (req_valid) begin
               func_in = req_func; cnt_in = req_page_count; res_in = '0;
               stat_in = pba_pkg::STATUS_DONE; dirty_in = 1'b0; mode_in = 1'b0;
               len_in = '0; pass_in = 1'b0; widx_in = start_w;
               pos_in = (req_func == pba_pkg::FUNC_ALLOC_RUN) ? 17'd0
                                                             : 17'(req_address >> 12);
               state_in = pba_pkg::ST_RD;
               if (req_func == pba_pkg::FUNC_ALLOC_RUN && req_page_count == 17'd1)
                  func_in = pba_pkg::FUNC_ALLOC_PAGE;
               unique case (req_func) inside
                  pba_pkg::FUNC_ALLOC_PAGE: if (start_w == end_w) begin
                     pass_in = 1'b1; widx_in = '0;
                     if (start_w == '0) begin
                        stat_in = pba_pkg::STATUS_NOSPACE; state_in = pba_pkg::ST_RESP;
                     end
                  end
                  pba_pkg::FUNC_ALLOC_RUN: begin
                     if (req_page_count == 17'd0) begin
                        stat_in = pba_pkg::STATUS_IGNORED; state_in = pba_pkg::ST_RESP;
                     end else if (req_page_count == 17'd1) begin
                        if (start_w == end_w) begin
                           pass_in = 1'b1; widx_in = '0;
                           if (start_w == '0) begin
                              stat_in = pba_pkg::STATUS_NOSPACE;
                              state_in = pba_pkg::ST_RESP;
                           end
                        end
                     end else if (etotal == 17'd0) begin
                        stat_in = pba_pkg::STATUS_NOSPACE; state_in = pba_pkg::ST_RESP;
                     end
                  end
                  pba_pkg::FUNC_FREE_PAGE: begin
                     if (req_address == '0 || req_address[11:0] != '0
                         || 17'(req_address >> 12) >= etotal) begin
                        stat_in = pba_pkg::STATUS_IGNORED; state_in = pba_pkg::ST_RESP;
                     end
                  end
                  pba_pkg::FUNC_MARK_USED, pba_pkg::FUNC_MARK_FREE: begin
                     if (req_page_count == '0) state_in = pba_pkg::ST_RESP;
                  end
                  default: begin
                     stat_in = pba_pkg::STATUS_IGNORED; state_in = pba_pkg::ST_RESP;
                  end
               endcase
            end
         end
         pba_pkg::ST_RD: state_in = pba_pkg::ST_WAIT;
         pba_pkg::ST_WAIT: begin
            word_in = rdata; dirty_in = 1'b0; state_in = pba_pkg::ST_EXEC;
         end
         pba_pkg::ST_EXEC: begin
            case (func_ff)
               pba_pkg::FUNC_ALLOC_PAGE: begin
                  if (!word_full) begin
                     if (17'({widx_ff[W-1:0], lz}) >= etotal) begin
                        stat_in = pba_pkg::STATUS_NOSPACE; state_in = pba_pkg::ST_RESP;
                     end else begin
                        word_in = word_ff | (64'd1 << lz); dirty_in = 1'b1;
                        free_in = free_ff - 1'b1;
                        hint_in = 17'({widx_ff[W-1:0], lz}) + 1'b1;
                        res_in = 28'({widx_ff[W-1:0], lz}) << 12;
                        state_in = pba_pkg::ST_WR;
                     end
                  end else begin
                     widx_in = widx_ff + 1'b1; state_in = pba_pkg::ST_RD;
                     if (!pass_ff && widx_ff + 1'b1 >= end_w) begin
                        pass_in = 1'b1; widx_in = '0;
                        if (start_w == '0) begin
                           stat_in = pba_pkg::STATUS_NOSPACE; state_in = pba_pkg::ST_RESP;
                        end
                     end else if (pass_ff && widx_ff + 1'b1 >= start_w) begin
                        stat_in = pba_pkg::STATUS_NOSPACE; state_in = pba_pkg::ST_RESP;
                     end
                  end
               end
               pba_pkg::FUNC_ALLOC_RUN: begin
                  state_in = pba_pkg::ST_EXEC;
                  if (mode_ff) begin
                     word_in = word_ff | (64'd1 << pos_ff[5:0]); dirty_in = 1'b1;
                     free_in = free_ff - 1'b1;
                     len_in = len_ff - 1'b1; pos_in = pos_ff + 1'b1;
                     if (len_ff == 17'd1) state_in = pba_pkg::ST_WR;
                     else if (pos_ff[5:0] == 6'd63) state_in = pba_pkg::ST_WR;
                  end else begin
                     if (bit_used) len_in = '0;
                     else begin
                        len_in = len_ff + 1'b1;
                        if (len_ff == '0) start_in = pos_ff;
                     end
                     pos_in = pos_ff + 1'b1;
                     if (!bit_used && len_ff + 1'b1 == cnt_ff) begin
                        mode_in = 1'b1; len_in = cnt_ff;
                        pos_in = (len_ff == '0) ? pos_ff : start_ff;
                        res_in = 28'((len_ff == '0) ? pos_ff : start_ff) << 12;
                        state_in = pba_pkg::ST_RD;
                     end else if (pos_ff + 1'b1 >= etotal) begin
                        stat_in = pba_pkg::STATUS_NOSPACE; state_in = pba_pkg::ST_RESP;
                     end else if (pos_ff[5:0] == 6'd63) state_in = pba_pkg::ST_RD;
                  end
               end
               pba_pkg::FUNC_FREE_PAGE: begin
                  if (!bit_used) begin
                     stat_in = pba_pkg::STATUS_IGNORED; state_in = pba_pkg::ST_RESP;
                  end else begin
                     word_in = word_ff & ~(64'd1 << pos_ff[5:0]); dirty_in = 1'b1;
                     free_in = free_ff + 1'b1;
                     if (pos_ff < hint_ff) hint_in = pos_ff;
                     state_in = pba_pkg::ST_WR;
                  end
               end
               default: begin
                  if (pos_ff >= 17'(pba_pkg::NumPages)) begin
                     state_in = dirty_ff ? pba_pkg::ST_WR : pba_pkg::ST_RESP;
                     cnt_in = '0;
                  end else begin
                     if (func_ff == pba_pkg::FUNC_MARK_USED && !bit_used) begin
                        word_in = word_ff | (64'd1 << pos_ff[5:0]); dirty_in = 1'b1;
                        free_in = free_ff - 1'b1;
                     end else if (func_ff == pba_pkg::FUNC_MARK_FREE && bit_used) begin
                        word_in = word_ff & ~(64'd1 << pos_ff[5:0]); dirty_in = 1'b1;
                        free_in = free_ff + 1'b1;
                     end
                     cnt_in = cnt_ff - 1'b1; pos_in = pos_ff + 1'b1;
                     if (cnt_ff == 17'd1 || pos_ff[5:0] == 6'd63) state_in = pba_pkg::ST_WR;
                  end
               end
            endcase
         end
         pba_pkg::ST_WR: begin
            mreq.we = 1'b1;
            mreq.waddr = (func_ff == pba_pkg::FUNC_ALLOC_PAGE) ? widx_ff[W-1:0]
                                                              : pos_prev[PW-1:6];
            if (func_ff == pba_pkg::FUNC_FREE_PAGE) mreq.waddr = pos_ff[PW-1:6];
            state_in = pba_pkg::ST_RESP;
            if ((func_ff == pba_pkg::FUNC_MARK_USED || func_ff == pba_pkg::FUNC_MARK_FREE)
                && cnt_ff != '0 && pos_ff < 17'(pba_pkg::NumPages))
               state_in = pba_pkg::ST_RD;
            if (func_ff == pba_pkg::FUNC_ALLOC_RUN && len_ff != '0)
               state_in = pba_pkg::ST_RD;
            mreq.raddr = mreq.waddr;
         end
         pba_pkg::ST_RESP: begin
            if (!rsp_stall) state_in = pba_pkg::ST_IDLE;
         end
         default: state_in = pba_pkg::ST_IDLE;
      endcase
   end

   assign req_stall = (state_ff != pba_pkg::ST_IDLE);
   assign rsp_valid = (state_ff == pba_pkg::ST_RESP);
   assign rsp_result_address = res_ff;
   assign rsp_status = stat_ff;
   assign rsp_free_count = free_ff;
endmodule

@@ sv/pba_checker.sv @@
// Port-level checker for the page bitmap allocator, bound to the top level.
`include "assert_macros.svh"
module pba_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [27:0] rsp_result_address,
   input logic [1:0]  rsp_status,
   input logic [16:0] rsp_free_count
);
   `ASSERT_IMPLY(a_busy, clock, reset, rsp_valid, req_stall)
   `ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && !req_stall, req_stall)
   `ASSERT_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_status) && $stable(rsp_result_address) && $stable(rsp_free_count))
   `ASSERT_IMPLY(a_status, clock, reset, rsp_valid, rsp_status <= pba_pkg::STATUS_IGNORED)
   `ASSERT_IMPLY(a_fail_zero, clock, reset, rsp_valid && rsp_status != pba_pkg::STATUS_DONE, rsp_result_address == 28'd0)
endmodule

bind page_bitmap_allocator_unit pba_checker u_pba_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_result_address(rsp_result_address),
   .rsp_status(rsp_status), .rsp_free_count(rsp_free_count)
);

@@ tb/page_bitmap_allocator_unit_tb.sv @@
// Self-checking testbench of the page bitmap allocator unit.
`timescale 1ns / 1ps

module page_bitmap_allocator_unit_tb;
   localparam logic [2:0] FUNC_RSVD_A = 3'd5;
   localparam logic [2:0] FUNC_RSVD_C = 3'd7;
   localparam int         HOLD_CYCLES = 3000;
   localparam int         CYCLE_LIMIT = 4000000;
   localparam int         NUM_PAGES   = pba_pkg::NumPages;

   typedef struct {
      logic [2:0]  func;
      logic [27:0] address;
      logic [16:0] page_count;
   } command_type;

   typedef struct {
      logic [27:0] result_address;
      logic [1:0]  status;
      logic [16:0] free_count;
   } result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_func = '0;
   logic [27:0] req_address = '0;
   logic [16:0] req_page_count = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [27:0] rsp_result_address;
   logic [1:0]  rsp_status;
   logic [16:0] rsp_free_count;
   logic        csr_we = 1'b0;
   logic [16:0] csr_wdata = '0;

   command_type pending_cmds[$];
   result_type  expected_results[$];
   bit          used_map[NUM_PAGES];
   int unsigned free_pages_m;
   int unsigned hint_m;
   int unsigned total_m;
   int          error_count = 0;
   int          gap_left = 0;
   int          stall_left = 0;
   logic        hold_request = 1'b0;
   longint      cycle_count = 0;

   page_bitmap_allocator_unit DUT (.*);

   always #6 clock = ~clock;

   function automatic int unsigned tracked_pages();
      return total_m > NUM_PAGES ? NUM_PAGES : total_m;
   endfunction

   function automatic bit take_one_page(output int unsigned page);
      int unsigned t, end_w, start_w, lo, hi, p, b;
      t = tracked_pages();
      end_w = (t + 63) / 64;
      start_w = hint_m / 64;
      if (start_w > end_w) start_w = end_w;
      for (int pass = 0; pass < 2; pass++) begin
         lo = pass == 0 ? start_w : 0;
         hi = pass == 0 ? end_w : start_w;
         for (int unsigned w = lo; w < hi; w++) begin
            b = 64;
            for (int k = 63; k >= 0; k--) begin
               if (!used_map[w * 64 + k]) b = k;
            end
            if (b == 64) continue;
            p = w * 64 + b;
            if (p >= t) return 1'b0;
            used_map[p] = 1'b1;
            free_pages_m--;
            hint_m = p + 1;
            page = p;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic bit take_page_run(int unsigned count, output int unsigned page);
      int unsigned t, start, len;
      t = tracked_pages();
      start = 0;
      len = 0;
      for (int unsigned p = 0; p < t; p++) begin
         if (used_map[p]) begin
            len = 0;
            continue;
         end
         if (len == 0) start = p;
         len++;
         if (len == count) begin
            for (int unsigned i = 0; i < count; i++) used_map[start + i] = 1'b1;
            free_pages_m -= count;
            page = start;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic void mark_pages(int unsigned first, int unsigned count, bit used);
      int unsigned p;
      for (int unsigned i = 0; i < count; i++) begin
         p = first + i;
         if (p >= NUM_PAGES) break;
         if (used && !used_map[p]) begin
            used_map[p] = 1'b1;
            free_pages_m--;
         end else if (!used && used_map[p]) begin
            used_map[p] = 1'b0;
            free_pages_m++;
         end
      end
   endfunction

   function automatic result_type allocate_result(command_type c);
      result_type  r;
      int unsigned first, page;
      bit          ok;
      first = c.address / 4096;
      r.result_address = '0;
      r.status = pba_pkg::STATUS_DONE;
      case (c.func)
         pba_pkg::FUNC_ALLOC_PAGE, pba_pkg::FUNC_ALLOC_RUN: begin
            if (c.func == pba_pkg::FUNC_ALLOC_RUN && c.page_count == 0) begin
               r.status = pba_pkg::STATUS_IGNORED;
            end else begin
               if (c.func == pba_pkg::FUNC_ALLOC_PAGE || c.page_count == 1)
                  ok = take_one_page(page);
               else ok = take_page_run(c.page_count, page);
               if (ok) r.result_address = 28'(page * 4096);
               else r.status = pba_pkg::STATUS_NOSPACE;
            end
         end
         pba_pkg::FUNC_FREE_PAGE: begin
            if (c.address == 0 || c.address[11:0] != 0 || first >= tracked_pages()
                || !used_map[first]) begin
               r.status = pba_pkg::STATUS_IGNORED;
            end else begin
               used_map[first] = 1'b0;
               free_pages_m++;
               if (first < hint_m) hint_m = first;
            end
         end
         pba_pkg::FUNC_MARK_USED: mark_pages(first, c.page_count, 1'b1);
         pba_pkg::FUNC_MARK_FREE: mark_pages(first, c.page_count, 1'b0);
         default: r.status = pba_pkg::STATUS_IGNORED;
      endcase
      r.free_count = 17'(free_pages_m);
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      command_type c;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_stall) begin
         c.func = req_func;
         c.address = req_address;
         c.page_count = req_page_count;
         expected_results.push_back(allocate_result(c));
         req_valid <= 1'b0;
         gap_left <= $urandom_range(0, 1) ? 0 : $urandom_range(1, 19);
      end else if (!req_valid) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
         end else if (pending_cmds.size() > 0) begin
            c = pending_cmds.pop_front();
            req_func <= c.func;
            req_address <= c.address;
            req_page_count <= c.page_count;
            req_valid <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      result_type e;
      int         n;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected word", rsp_status, 0);
         end else begin
            e = expected_results.pop_front();
            if (rsp_result_address !== e.result_address)
               report_mismatch("result_address", rsp_result_address, e.result_address);
            if (rsp_status !== e.status)
               report_mismatch("status", rsp_status, e.status);
            if (rsp_free_count !== e.free_count)
               report_mismatch("free_count", rsp_free_count, e.free_count);
         end
         n = $urandom_range(0, 1) ? 0 : $urandom_range(1, 19);
         if (hold_request) begin
            n = HOLD_CYCLES;
            hold_request <= 1'b0;
         end
         stall_left <= n;
         rsp_stall <= n != 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= stall_left > 1;
      end
   end

   function automatic command_type make_cmd(logic [2:0] f, logic [27:0] a, logic [16:0] n);
      command_type c;
      c.func = f;
      c.address = a;
      c.page_count = n;
      return c;
   endfunction

   task automatic wait_idle();
      do @(posedge clock);
      while (pending_cmds.size() != 0 || req_valid || expected_results.size() != 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_total(int unsigned v);
      csr_we <= 1'b1;
      csr_wdata <= 17'(v);
      @(posedge clock);
      csr_we <= 1'b0;
      total_m = v;
   endtask

   task automatic queue_random(int num, bit wide_total);
      int unsigned r, lim, page, cnt;
      logic [2:0]  f;
      logic [27:0] a;
      lim = tracked_pages() + 70;
      if (lim > NUM_PAGES - 1) lim = NUM_PAGES - 1;
      for (int i = 0; i < num; i++) begin
         r = $urandom_range(0, 99);
         if (r < 30) f = pba_pkg::FUNC_ALLOC_PAGE;
         else if (r < 42) f = pba_pkg::FUNC_ALLOC_RUN;
         else if (r < 65) f = pba_pkg::FUNC_FREE_PAGE;
         else if (r < 80) f = pba_pkg::FUNC_MARK_USED;
         else if (r < 95) f = pba_pkg::FUNC_MARK_FREE;
         else f = 3'($urandom_range(FUNC_RSVD_A, FUNC_RSVD_C));
         if ($urandom_range(0, 9) == 0) a = 28'($urandom);
         else if ($urandom_range(0, 9) == 0)
            a = 28'($urandom_range(NUM_PAGES - 80, NUM_PAGES - 1)) << 12;
         else a = 28'($urandom_range(0, lim)) << 12;
         page = a / 4096;
         cnt = $urandom_range(0, 40);
         if (f == pba_pkg::FUNC_ALLOC_RUN) begin
            if (wide_total) cnt = 1;
            else if ($urandom_range(0, 9) == 0) cnt = $urandom_range(0, 131071);
            else cnt = $urandom_range(0, 8);
         end else if (page >= NUM_PAGES - 80 && $urandom_range(0, 3) == 0) begin
            cnt = $urandom_range(0, 131071);
         end
         pending_cmds.push_back(make_cmd(f, a, 17'(cnt)));
      end
   endtask

   initial begin
      foreach (used_map[i]) used_map[i] = 1'b1;
      free_pages_m = 0;
      hint_m = 0;
      total_m = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_total(0);
      pending_cmds.push_back(make_cmd(pba_pkg::FUNC_ALLOC_PAGE, '0, '0));
      pending_cmds.push_back(make_cmd(pba_pkg::FUNC_FREE_PAGE, 28'h1000, '0));
      pending_cmds.push_back(make_cmd(pba_pkg::FUNC_ALLOC_RUN, '0, '0));
      pending_cmds.push_back(make_cmd(pba_pkg::FUNC_MARK_FREE, '0, '0));
      for (int f = FUNC_RSVD_A; f <= FUNC_RSVD_C; f++)
         pending_cmds.push_back(make_cmd(3'(f), 28'hFFFFFFF, 17'h1FFFF));
      wait_idle();
      write_total(130);
      pending_cmds.push_back(make_cmd(pba_pkg::FUNC_MARK_FREE, '0, 17'd200));
      pending_cmds.push_back(make_cmd(pba_pkg::FUNC_ALLOC_PAGE, '0, '0));
      pending_cmds.push_back(make_cmd(pba_pkg::FUNC_ALLOC_RUN, '0, 17'd1));
      pending_cmds.push_back(make_cmd(pba_pkg::FUNC_ALLOC_RUN, '0, 17'd3));
      pending_cmds.push_back(make_cmd(pba_pkg::FUNC_ALLOC_RUN, '0, 17'h10000));
      pending_cmds.push_back(make_cmd(pba_pkg::FUNC_FREE_PAGE, '0, '0));
      pending_cmds.push_back(make_cmd(pba_pkg::FUNC_FREE_PAGE, 28'h1008, '0));
      pending_cmds.push_back(make_cmd(pba_pkg::FUNC_FREE_PAGE, 28'd140 << 12, '0));
      pending_cmds.push_back(make_cmd(pba_pkg::FUNC_FREE_PAGE, 28'd100 << 12, '0));
      pending_cmds.push_back(make_cmd(pba_pkg::FUNC_FREE_PAGE, 28'd2 << 12, '0));
      pending_cmds.push_back(make_cmd(pba_pkg::FUNC_MARK_USED, 28'hFFFF000, 17'h1FFFF));
      pending_cmds.push_back(make_cmd(pba_pkg::FUNC_MARK_FREE, 28'hFFFF000, 17'h1FFFF));
      pending_cmds.push_back(make_cmd(pba_pkg::FUNC_MARK_USED, '0, 17'd120));
      for (int i = 0; i < 12; i++)
         pending_cmds.push_back(make_cmd(pba_pkg::FUNC_ALLOC_PAGE, '0, '0));
      wait_idle();
      queue_random(80, 1'b0);
      wait_idle();
      write_total(64);
      queue_random(80, 1'b0);
      wait_idle();
      write_total(1);
      queue_random(50, 1'b0);
      wait_idle();
      write_total(200);
      pending_cmds.push_back(make_cmd(pba_pkg::FUNC_MARK_FREE, '0, 17'd200));
      @(posedge clock);
      hold_request <= 1'b1;
      queue_random(90, 1'b0);
      wait_idle();
      write_total(NUM_PAGES);
      pending_cmds.push_back(make_cmd(pba_pkg::FUNC_MARK_FREE, 28'd65400 << 12, 17'd100));
      queue_random(90, 1'b1);
      wait_idle();
      write_total(131071);
      queue_random(90, 1'b1);
      wait_idle();
      write_total(0);
      queue_random(40, 1'b0);
      wait_idle();
      repeat (50) @(posedge clock);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
